[hw/rtl/id_depth_outline_pass_unit_defines.svh]
// Assertion macros used by the checker of the outline pass.
// Depends on nothing; the using module supplies clk and rst_n.
`ifndef ID_DEPTH_OUTLINE_PASS_UNIT_DEFINES_SVH
`define ID_DEPTH_OUTLINE_PASS_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define IDOP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define IDOP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/idop_pkg.sv]
// Types, constants and the accent table of the id/depth outline pass.
// No dependencies; used by the top level and its checker.
package idop_pkg;

  localparam int MAX_WIDTH     = 4096;
  localparam int X_W           = $clog2(MAX_WIDTH);
  localparam int XC_W          = X_W + 1;
  localparam int ADDR_W        = X_W + 1;
  localparam int LINE_DEPTH    = 2 * MAX_WIDTH;
  localparam int FW_W          = 13;
  localparam int PADDR_W       = 5;
  localparam int ACCENT_COUNT  = 6;
  localparam int OWN_W         = 15;
  localparam int ACC_SHIFT     = 20;
  localparam int ACC_RECIP_W   = ACC_SHIFT + 1;
  localparam int ACC_RECIP     = ((1 << ACC_SHIFT) + ACCENT_COUNT - 1) / ACCENT_COUNT;
  localparam int DIFF_W        = 33;
  localparam int RHS_W         = 48;
  localparam int THR_FRAC      = 12;
  localparam int DEPTH_ONE     = 65536;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH    = 3'd0,
    REG_FRAME_HEIGHT   = 3'd1,
    REG_DEPTH_THRESH   = 3'd2,
    REG_SELECTED_ID    = 3'd3,
    REG_HOVERED_ID     = 3'd4,
    REG_OUTLINE_ONLY   = 3'd5,
    REG_SELECTED_COLOR = 3'd6,
    REG_HOVER_COLOR    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [31:0]        pixel_color;
    logic signed [15:0] owner_id;
    logic signed [31:0] pixel_depth;
    logic               depth_valid;
  } in_word_t;

  typedef struct packed {
    logic [31:0] out_color;
    logic [11:0] out_x;
    logic [15:0] out_y;
    logic        is_outline;
    logic        last_of_run;
  } out_word_t;

  // One line store entry.
  typedef struct packed {
    logic [31:0]        color;
    logic signed [15:0] owner;
    logic               dvalid;
    logic signed [31:0] depth;
  } line_entry_t;

  localparam logic [31:0] ACCENT_TABLE [16] = '{
    32'h4CB0E8FA, 32'h5BC5B5FA, 32'h84A2EEFA, 32'hAE8FDCFA,
    32'h63BCDDFA, 32'h73CD9DFA, 32'h4CB0E8FA, 32'h5BC5B5FA,
    32'h84A2EEFA, 32'hAE8FDCFA, 32'h63BCDDFA, 32'h73CD9DFA,
    32'h4CB0E8FA, 32'h5BC5B5FA, 32'h84A2EEFA, 32'hAE8FDCFA
  };

  function automatic logic [31:0] accent_color(input logic [3:0] idx);
    return ACCENT_TABLE[idx];
  endfunction

endpackage

[hw/rtl/id_depth_outline_pass_unit.sv]
// Top level of the object-id / depth edge outline pass.
// Depends on idop_pkg (types, constants, accent table).

// Streams raster-order pixels and emits each pixel one row late, once the
// pixel below it has arrived. An interior pixel with alpha != 0, id >= 0
// and valid depth is outline when any 4-neighbor is empty, carries another
// id, or steps in depth by more than threshold*(1+|depth|); outline pixels
// take the selected, hover or accent color, others pass (or clear to zero
// with outline_only). Rate: one pixel per clock while out_stall is low; on the
// last row of a frame every pixel yields two words (the pixel above, then
// itself) through the single output port, so there the input stalls while
// each pair drains. A word leaves once the pixel below it is accepted and
// has passed memory read, compare prep and compare/select. State is one
// 8192 x 81 bit line store (two rows), one write and two reads per accepted
// pixel; no clearing pass, entries are valid once the first row is written.
// Registers (APB, byte address 4*i): 0 frame_width, 1 frame_height,
// 2 depth_threshold (Q4.12), 3 selected_id, 4 hovered_id, 5 outline_only,
// 6 selected_color, 7 hover_color. Write them only while idle.
module id_depth_outline_pass_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [idop_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  idop_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output idop_pkg::out_word_t           out_data
);
  import idop_pkg::*;

  // ---------------- configuration registers ----------------
  logic [FW_W-1:0]    fw_r;
  logic [15:0]        fh_r;
  logic [15:0]        thr_r;
  logic signed [15:0] sel_id_r;
  logic signed [15:0] hov_id_r;
  logic               oonly_r;
  logic [31:0]        sel_color_r;
  logic [31:0]        hov_color_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r        <= FW_W'(640);
      fh_r        <= 16'd480;
      thr_r       <= 16'd0;
      sel_id_r    <= -16'sd1;
      hov_id_r    <= -16'sd1;
      oonly_r     <= 1'b0;
      sel_color_r <= 32'hFFA84CFF;
      hov_color_r <= 32'h68E8FFFF;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:    fw_r        <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT:   fh_r        <= pwdata[15:0];
        REG_DEPTH_THRESH:   thr_r       <= pwdata[15:0];
        REG_SELECTED_ID:    sel_id_r    <= pwdata[15:0];
        REG_HOVERED_ID:     hov_id_r    <= pwdata[15:0];
        REG_OUTLINE_ONLY:   oonly_r     <= pwdata[0];
        REG_SELECTED_COLOR: sel_color_r <= pwdata;
        REG_HOVER_COLOR:    hov_color_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:    prdata = 32'(fw_r);
      REG_FRAME_HEIGHT:   prdata = 32'(fh_r);
      REG_DEPTH_THRESH:   prdata = 32'(thr_r);
      REG_SELECTED_ID:    prdata = 32'(sel_id_r);
      REG_HOVERED_ID:     prdata = 32'(hov_id_r);
      REG_OUTLINE_ONLY:   prdata = 32'(oonly_r);
      REG_SELECTED_COLOR: prdata = sel_color_r;
      REG_HOVER_COLOR:    prdata = hov_color_r;
      default:            prdata = 32'd0;
    endcase
  end

  // Effective geometry: width saturated into 3..MAX_WIDTH, height >= 3.
  logic [XC_W-1:0] w_eff;
  logic [15:0]     h_eff;

  always_comb begin
    if (fw_r > FW_W'(MAX_WIDTH))  w_eff = XC_W'(MAX_WIDTH);
    else if (fw_r < FW_W'(3))     w_eff = XC_W'(3);
    else                          w_eff = XC_W'(fw_r);
    h_eff = (fh_r < 16'd3) ? 16'd3 : fh_r;
  end

  // ---------------- pipeline control ----------------
  // s1: item with line store read data. s2: compare operands.
  // Output pair register: one or two words per item.
  logic s1_v_r, s2_v_r;
  logic s1_adv, s2_adv, out_free, out_take;
  logic accept;
  logic s2_emit_r;

  logic      pair_v_r, phase_r, has2_r;
  out_word_t res0_r, res1_r;

  assign out_take = pair_v_r && !out_stall;
  assign out_free = !pair_v_r || (out_take && (phase_r || !has2_r));
  assign s2_adv   = !s2_v_r || !s2_emit_r || out_free;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_stall = !s1_adv;
  assign accept   = in_valid && s1_adv;

  // ---------------- raster counters ----------------
  logic [X_W-1:0]  col_r;
  logic [15:0]     row_r;
  logic [XC_W-1:0] xp1;
  logic [16:0]     yp1;
  logic            end_row, last_row;

  assign xp1      = {1'b0, col_r} + XC_W'(1);
  assign yp1      = {1'b0, row_r} + 17'd1;
  assign end_row  = xp1 >= w_eff;
  assign last_row = yp1 >= {1'b0, h_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (end_row) begin
        col_r <= '0;
        row_r <= last_row ? 16'd0 : yp1[15:0];
      end else begin
        col_r <= xp1[X_W-1:0];
      end
    end
  end

  // ---------------- line store ----------------
  // Row parity y[0] is the row being written; the other half holds the row
  // above. Per pixel: read the right neighbor of the center (row above,
  // x+1) and the pixel two rows up (same half, x, read before the write).
  // At the row end the right neighbor is a border, so that port fetches
  // entry 0 of the row just finished: the first center of the next row.
  // All accesses happen at accept in model order, so no forwarding needed.
  line_entry_t     line_mem [LINE_DEPTH];
  line_entry_t     wr_entry;
  line_entry_t     rd_ahead_r, rd_above_r;
  logic [ADDR_W-1:0] wr_addr, ahead_addr;

  assign wr_entry   = '{color:  in_data.pixel_color, owner: in_data.owner_id,
                        dvalid: in_data.depth_valid, depth: in_data.pixel_depth};
  assign wr_addr    = {row_r[0], col_r};
  assign ahead_addr = end_row ? {row_r[0], X_W'(0)} : {~row_r[0], xp1[X_W-1:0]};

  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[wr_addr] <= wr_entry;
      rd_ahead_r        <= line_mem[ahead_addr];
      rd_above_r        <= line_mem[wr_addr];
    end
  end

  // ---------------- stage 1 ----------------
  line_entry_t    s1_pix_r;
  logic [X_W-1:0] s1_x_r;
  logic [15:0]    s1_y_r;
  logic           s1_emit_r, s1_int_r, s1_last_r;
  line_entry_t    win_c_r, win_l_r;   // center and left of the row above

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (s1_adv) s1_v_r <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= wr_entry;
      s1_x_r    <= col_r;
      s1_y_r    <= row_r;
      s1_emit_r <= row_r != 16'd0;
      s1_int_r  <= (col_r != '0) && !end_row && (row_r != 16'd1);
      s1_last_r <= last_row;
    end
    if (s1_v_r && s1_adv) begin
      win_l_r <= win_c_r;
      win_c_r <= rd_ahead_r;
    end
  end

  // Neighbors: 0 left, 1 right, 2 above, 3 below (the new pixel).
  line_entry_t                nb [4];
  logic [3:0]                 hard, chk;
  logic [DIFF_W-1:0]          dd   [4];
  logic [DIFF_W-1:0]          dmag [4];
  logic [31:0]                abs_cd;
  logic [32:0]                rhs_base;
  logic [48:0]                rhs_full;
  logic                       cen_ok;
  logic [OWN_W+ACC_RECIP_W-1:0] q_prod;

  assign nb[0] = win_l_r;
  assign nb[1] = rd_ahead_r;
  assign nb[2] = rd_above_r;
  assign nb[3] = s1_pix_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hard[i] = (nb[i].color[7:0] == 8'd0) || nb[i].owner[15]
             || (nb[i].owner != win_c_r.owner);
      chk[i]  = nb[i].dvalid;
      dd[i]   = {win_c_r.depth[31], win_c_r.depth} - {nb[i].depth[31], nb[i].depth};
      dmag[i] = dd[i][DIFF_W-1] ? (~dd[i] + DIFF_W'(1)) : dd[i];
    end
    abs_cd   = win_c_r.depth[31] ? (~win_c_r.depth + 32'd1) : win_c_r.depth;
    rhs_base = {1'b0, abs_cd} + 33'(DEPTH_ONE);
    rhs_full = thr_r * rhs_base;
    cen_ok   = s1_int_r && (win_c_r.color[7:0] != 8'd0) && !win_c_r.owner[15]
            && win_c_r.dvalid;
    q_prod   = win_c_r.owner[OWN_W-1:0] * ACC_RECIP_W'(ACC_RECIP);
  end

  // ---------------- stage 2 ----------------
  logic              s2_cen_ok_r, s2_last_r;
  logic [3:0]        s2_hard_r, s2_chk_r;
  logic [DIFF_W-1:0] s2_dmag_r [4];
  logic [RHS_W-1:0]  s2_rhs_r;
  logic [OWN_W-1:0]  s2_q_r;
  logic [31:0]       s2_cen_color_r, s2_dn_color_r;
  logic signed [15:0] s2_owner_r;
  logic [X_W-1:0]    s2_x_r;
  logic [15:0]       s2_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (s2_adv) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_emit_r      <= s1_emit_r;
      s2_cen_ok_r    <= cen_ok;
      s2_last_r      <= s1_last_r;
      s2_hard_r      <= hard;
      s2_chk_r       <= chk;
      s2_dmag_r      <= dmag;
      s2_rhs_r       <= rhs_full[RHS_W-1:0];
      s2_q_r         <= q_prod[ACC_SHIFT +: OWN_W];
      s2_cen_color_r <= win_c_r.color;
      s2_owner_r     <= win_c_r.owner;
      s2_dn_color_r  <= s1_pix_r.color;
      s2_x_r         <= s1_x_r;
      s2_y_r         <= s1_y_r;
    end
  end

  logic [3:0]       depth_hit;
  logic             outl;
  logic [OWN_W-1:0] acc_rem;
  logic [31:0]      ocolor;
  out_word_t        res0_nxt, res1_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      depth_hit[i] = s2_chk_r[i]
                  && ({3'b0, s2_dmag_r[i], THR_FRAC'(0)} > s2_rhs_r);
    end
    outl    = s2_cen_ok_r && |(s2_hard_r | depth_hit);
    acc_rem = s2_owner_r[OWN_W-1:0] - OWN_W'(s2_q_r * OWN_W'(ACCENT_COUNT));
    if (s2_owner_r == sel_id_r)      ocolor = sel_color_r;
    else if (s2_owner_r == hov_id_r) ocolor = hov_color_r;
    else                             ocolor = accent_color(acc_rem[3:0]);

    res0_nxt.out_color   = outl ? ocolor : (oonly_r ? 32'd0 : s2_cen_color_r);
    res0_nxt.out_x       = 12'(s2_x_r);
    res0_nxt.out_y       = s2_y_r - 16'd1;
    res0_nxt.is_outline  = outl;
    res0_nxt.last_of_run = !s2_last_r;

    res1_nxt.out_color   = oonly_r ? 32'd0 : s2_dn_color_r;
    res1_nxt.out_x       = 12'(s2_x_r);
    res1_nxt.out_y       = s2_y_r;
    res1_nxt.is_outline  = 1'b0;
    res1_nxt.last_of_run = 1'b1;
  end

  // ---------------- output pair register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_v_r <= 1'b0;
      phase_r  <= 1'b0;
      has2_r   <= 1'b0;
    end else if (out_free) begin
      pair_v_r <= s2_v_r && s2_emit_r;
      phase_r  <= 1'b0;
      has2_r   <= s2_last_r;
    end else if (out_take) begin
      phase_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      res0_r <= res0_nxt;
      res1_r <= res1_nxt;
    end
  end

  assign out_valid = pair_v_r;
  assign out_data  = phase_r ? res1_r : res0_r;

endmodule

[hw/rtl/idop_checker.sv]
// Port-level checker for the outline pass, bound to the top level.
// Depends on idop_pkg and id_depth_outline_pass_unit_defines.svh.
`include "id_depth_outline_pass_unit_defines.svh"

module idop_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [idop_pkg::PADDR_W-1:0]  paddr,
  input logic [31:0]                   pwdata,
  input logic [31:0]                   prdata,
  input logic                          pready,
  input logic                          in_valid,
  input logic                          in_stall,
  input idop_pkg::in_word_t            in_data,
  input logic                          out_valid,
  input logic                          out_stall,
  input idop_pkg::out_word_t           out_data
);
  import idop_pkg::*;

  // A stalled word stays and holds its payload.
  `IDOP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "out word changed while stalled")

  // On the last row the pixel itself follows its upper neighbor at once.
  `IDOP_ASSERT_NEXT(a_pair_follow, out_valid && !out_stall && !out_data.last_of_run, out_valid && out_data.last_of_run && out_data.out_x == $past(out_data.out_x) && out_data.out_y == $past(out_data.out_y) + 16'd1, "last row pair broken")

  // First column is a border: never outline.
  `IDOP_ASSERT_SAME(a_border, out_valid && out_data.out_x == 12'd0, !out_data.is_outline, "outline on left border")

  // Selected color reads back what was written.
  `IDOP_ASSERT_SAME(a_readback, (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_SELECTED_COLOR) ##1 (psel && !pwrite && paddr == $past(paddr)), prdata == $past(pwdata), "selected color readback mismatch")

endmodule

bind id_depth_outline_pass_unit idop_checker u_idop_checker (.*);
